FILE: rtl/pts_ordered_jitter_buffer_assert.svh
// ----------------------------------------------------------------------------
// pts ordered jitter buffer assertion macros
// concurrent checks on the block clock, held off during reset
// ----------------------------------------------------------------------------
`ifndef PTS_ORDERED_JITTER_BUFFER_ASSERT_SVH
`define PTS_ORDERED_JITTER_BUFFER_ASSERT_SVH

// same-cycle implication
`define POJB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define POJB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pojb_pkg.sv
// ----------------------------------------------------------------------------
// pojb_pkg
// shared types and constants of the pts ordered jitter buffer
// ----------------------------------------------------------------------------
package pojb_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int TAG_BITS_DEF = 16;

    localparam int PTS_W      = 64;
    localparam int TAG_W      = 16;
    localparam int OCC_W      = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int LAT_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LATENCY = 1'b0,
        CFG_MAX_CAPACITY   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_TICK  = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        t_func                    func;
        logic signed [PTS_W-1:0]  frame_pts;
        logic [TAG_W-1:0]         frame_tag;
    } t_in_beat;

    typedef struct packed {
        logic                     push_accepted;
        logic                     frame_valid;
        logic signed [PTS_W-1:0]  out_pts;
        logic [TAG_W-1:0]         out_tag;
        logic [OCC_W-1:0]         occupancy;
        logic                     buffering;
    } t_out_beat;

endpackage

FILE: rtl/pts_ordered_jitter_buffer.sv
// ----------------------------------------------------------------------------
// pts_ordered_jitter_buffer
// jitter buffer that hands out frames in presentation timestamp order
// ----------------------------------------------------------------------------
// Entries sit in a ring-addressed RAM kept sorted by timestamp, oldest first
// among equal timestamps. One item is worked on at a time and the input is
// stalled until its result beat is loaded into the output register. A push
// into a buffer that already holds entries walks the RAM from the tail toward
// the head with one read, one signed 64-bit compare and one write per cycle,
// moving each stored entry with a later timestamp up by one place, and then
// writes the new entry in ST_INS or ST_FIN. A pop that delivers a frame reads
// the head entry in ST_IDLE and takes it in ST_POP; every other item, a push
// into an empty buffer and a refused push among them, goes straight to ST_RES.
// Each result waits in ST_RES while the previous beat is stalled on the output.
// The next item is taken while the previous result beat still waits on the
// output. No clearing pass is needed after reset.
module pts_ordered_jitter_buffer #(
    parameter int DEPTH    = pojb_pkg::DEPTH_DEF,
    parameter int TAG_BITS = pojb_pkg::TAG_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pojb_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pojb_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [pojb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pojb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int TW  = (TAG_BITS < pojb_pkg::TAG_W) ? TAG_BITS : pojb_pkg::TAG_W;
    localparam int DW  = pojb_pkg::PTS_W + TW;
    localparam int CMW = (CW > pojb_pkg::OCC_W) ? CW : pojb_pkg::OCC_W;
    localparam logic [AW:0]    DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]  LAST_A  = AW'(DEPTH - 1);
    localparam logic [CMW-1:0] DEPTH_C = CMW'(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INS  = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_POP  = 5'b01000,
        ST_RES  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_pos, n_pos;
    logic [AW-1:0]                       r_head, n_head;
    logic                                r_buf, n_buf;
    logic [pojb_pkg::LAT_W-1:0]          r_elapsed, n_elapsed;
    logic [pojb_pkg::LAT_W-1:0]          r_target, n_target;
    logic [pojb_pkg::OCC_W-1:0]          r_maxcap, n_maxcap;
    logic signed [pojb_pkg::PTS_W-1:0]   r_new_pts, n_new_pts;
    logic [TW-1:0]                       r_new_tag, n_new_tag;
    logic                                r_res_acc, n_res_acc;
    logic                                r_res_fv, n_res_fv;
    logic signed [pojb_pkg::PTS_W-1:0]   r_res_pts, n_res_pts;
    logic [TW-1:0]                       r_res_tag, n_res_tag;
    pojb_pkg::t_out_beat                 r_out, n_out;
    logic                                r_out_valid, n_out_valid;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [DW-1:0]                       ram_wdata;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    logic [DW-1:0]                       ram_rdata;

    logic signed [pojb_pkg::PTS_W-1:0]   rd_pts;
    logic [CMW-1:0]                      cnt_x;
    logic [CMW-1:0]                      cap_x;
    logic [CMW-1:0]                      eff_cap;
    logic                                cnt_zero;
    logic                                can_push;
    logic                                is_full;
    logic                                lat_met;
    logic [CW-1:0]                       last_idx;
    logic [CW-1:0]                       pos_m1;
    logic [CW-1:0]                       pos_m2;
    logic [AW-1:0]                       head_inc;
    logic [pojb_pkg::TAG_W-1:0]          res_tag16;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    pojb_ram #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_pts   = ram_rdata[DW-1 -: pojb_pkg::PTS_W];
    assign cnt_x    = CMW'(r_count);
    assign cap_x    = CMW'(r_maxcap);
    assign eff_cap  = (cap_x < DEPTH_C) ? cap_x : DEPTH_C;
    assign cnt_zero = (r_count == '0);
    assign can_push = (cnt_x < eff_cap);
    assign is_full  = (cnt_x >= eff_cap);
    assign lat_met  = (r_elapsed >= r_target);
    assign last_idx = r_count - CW'(1);
    assign pos_m1   = r_pos - CW'(1);
    assign pos_m2   = r_pos - CW'(2);
    assign head_inc = (r_head == LAST_A) ? '0 : r_head + AW'(1);

    always_comb begin
        res_tag16 = '0;
        res_tag16[TW-1:0] = r_res_tag;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_head      = r_head;
        n_buf       = r_buf;
        n_elapsed   = r_elapsed;
        n_target    = r_target;
        n_maxcap    = r_maxcap;
        n_new_pts   = r_new_pts;
        n_new_tag   = r_new_tag;
        n_res_acc   = r_res_acc;
        n_res_fv    = r_res_fv;
        n_res_pts   = r_res_pts;
        n_res_tag   = r_res_tag;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        if (i_cfg_we) begin
            unique case (pojb_pkg::t_cfg_idx'(i_cfg_idx))
                pojb_pkg::CFG_TARGET_LATENCY: n_target = i_cfg_data;
                pojb_pkg::CFG_MAX_CAPACITY:   n_maxcap = i_cfg_data[pojb_pkg::OCC_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_acc = 1'b0;
                    n_res_fv  = 1'b0;
                    n_res_pts = '0;
                    n_res_tag = '0;
                    n_state   = ST_RES;
                    unique case (i_in_data.func)
                        pojb_pkg::FN_PUSH: begin
                            if (can_push) begin
                                n_res_acc = 1'b1;
                                n_new_pts = i_in_data.frame_pts;
                                n_new_tag = i_in_data.frame_tag[TW-1:0];
                                n_pos     = r_count;
                                if (r_buf && cnt_zero) begin
                                    n_elapsed = '0;
                                end
                                if (cnt_zero) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_head;
                                    ram_wdata = {i_in_data.frame_pts,
                                                 i_in_data.frame_tag[TW-1:0]};
                                    n_count   = r_count + CW'(1);
                                end else begin
                                    ram_re    = 1'b1;
                                    ram_raddr = f_phys(r_head, last_idx[AW-1:0]);
                                    n_state   = ST_INS;
                                end
                            end
                        end
                        pojb_pkg::FN_POP: begin
                            if (cnt_zero) begin
                                n_buf = 1'b1;
                            end else if (!r_buf || lat_met || is_full) begin
                                n_buf     = 1'b0;
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_state   = ST_POP;
                            end
                        end
                        pojb_pkg::FN_TICK: begin
                            if (r_elapsed != '1) begin
                                n_elapsed = r_elapsed + pojb_pkg::LAT_W'(1);
                            end
                        end
                        pojb_pkg::FN_CLEAR: begin
                            n_count = '0;
                            n_buf   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS: begin
                if (rd_pts > r_new_pts) begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, r_pos[AW-1:0]);
                    ram_wdata = ram_rdata;
                    n_pos     = pos_m1;
                    if (pos_m1 == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = f_phys(r_head, pos_m2[AW-1:0]);
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, r_pos[AW-1:0]);
                    ram_wdata = {r_new_pts, r_new_tag};
                    n_count   = r_count + CW'(1);
                    n_state   = ST_RES;
                end
            end
            ST_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_head;
                ram_wdata = {r_new_pts, r_new_tag};
                n_count   = r_count + CW'(1);
                n_state   = ST_RES;
            end
            ST_POP: begin
                n_res_fv  = 1'b1;
                n_res_pts = rd_pts;
                n_res_tag = ram_rdata[TW-1:0];
                n_count   = last_idx;
                n_head    = head_inc;
                if (last_idx == '0) begin
                    n_buf = 1'b1;
                end
                n_state = ST_RES;
            end
            ST_RES: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.push_accepted = r_res_acc;
                    n_out.frame_valid   = r_res_fv;
                    n_out.out_pts       = r_res_pts;
                    n_out.out_tag       = res_tag16;
                    n_out.occupancy     = pojb_pkg::OCC_W'(r_count);
                    n_out.buffering     = r_buf;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_head      <= '0;
            r_buf       <= 1'b1;
            r_elapsed   <= '0;
            r_target    <= pojb_pkg::LAT_W'(50);
            r_maxcap    <= pojb_pkg::OCC_W'(64);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_head      <= n_head;
            r_buf       <= n_buf;
            r_elapsed   <= n_elapsed;
            r_target    <= n_target;
            r_maxcap    <= n_maxcap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_pts <= n_new_pts;
        r_new_tag <= n_new_tag;
        r_res_acc <= n_res_acc;
        r_res_fv  <= n_res_fv;
        r_res_pts <= n_res_pts;
        r_res_tag <= n_res_tag;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
`include "pts_ordered_jitter_buffer_assert.svh"

    `POJB_ASSERT_NXT(a_busy_after_beat, i_in_valid && !o_in_stall, o_in_stall, "input not held off while an item is in work")
    `POJB_ASSERT_IMP(a_empty_buffers, o_out_valid && (o_out_data.occupancy == '0), o_out_data.buffering, "empty buffer reported outside buffering")
    `POJB_ASSERT_IMP(a_pop_mode, o_out_valid && o_out_data.frame_valid, o_out_data.buffering == (o_out_data.occupancy == '0), "buffering state wrong after a delivered frame")

endmodule

FILE: rtl/pojb_ram.sv
// ----------------------------------------------------------------------------
// pojb_ram
// entry store: one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pojb_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sim/pojb_checker.sv
// ----------------------------------------------------------------------------
// pojb_checker
// watches both beat channels and the register port of the jitter buffer,
// keeps its own timestamp-sorted copy of the stored frames, predicts the
// result beat of every accepted item and compares it field by field
// ----------------------------------------------------------------------------
module pojb_checker
    import pojb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_beat              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_beat             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending,
    output int                    o_items,
    output int                    o_frames,
    output int                    o_refused
);

    localparam logic [LAT_W-1:0] LAT_RESET = 50;
    localparam logic [OCC_W-1:0] CAP_RESET = 64;

    typedef struct packed {
        logic signed [PTS_W-1:0] pts;
        logic [TAG_W-1:0]        tag;
    } t_frame;

    t_frame           frames_held[$];
    t_out_beat        awaited_results[$];
    logic [LAT_W-1:0] target_ms;
    logic [OCC_W-1:0] capacity;
    logic             prebuffering;
    logic [LAT_W-1:0] elapsed_ms;

    function automatic t_out_beat predict_result(input t_in_beat item);
        t_out_beat res;
        t_frame    fr;
        int        eff_cap;
        int        pos;
        res = '0;
        eff_cap = (capacity < DEPTH_DEF) ? int'(capacity) : DEPTH_DEF;
        case (item.func)
            FN_PUSH: begin
                if (frames_held.size() < eff_cap) begin
                    if (prebuffering && frames_held.size() == 0)
                        elapsed_ms = '0;
                    // equal timestamps keep arrival order
                    pos = frames_held.size();
                    while (pos > 0 && $signed(frames_held[pos-1].pts) > $signed(item.frame_pts))
                        pos--;
                    fr.pts = item.frame_pts;
                    fr.tag = item.frame_tag;
                    frames_held.insert(pos, fr);
                    res.push_accepted = 1'b1;
                end
            end
            FN_POP: begin
                if (frames_held.size() == 0) begin
                    prebuffering = 1'b1;
                end else begin
                    if (prebuffering && (elapsed_ms >= target_ms || frames_held.size() >= eff_cap))
                        prebuffering = 1'b0;
                    if (!prebuffering) begin
                        fr = frames_held.pop_front();
                        res.frame_valid = 1'b1;
                        res.out_pts     = fr.pts;
                        res.out_tag     = fr.tag;
                        if (frames_held.size() == 0)
                            prebuffering = 1'b1;
                    end
                end
            end
            FN_TICK: begin
                if (elapsed_ms != '1)
                    elapsed_ms++;
            end
            FN_CLEAR: begin
                frames_held.delete();
                prebuffering = 1'b1;
            end
        endcase
        res.occupancy = OCC_W'(frames_held.size());
        res.buffering = prebuffering;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            o_fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            frames_held.delete();
            awaited_results.delete();
            target_ms    = LAT_RESET;
            capacity     = CAP_RESET;
            prebuffering = 1'b1;
            elapsed_ms   = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected: expected none, actual %h",
                             $time, i_out_data);
                    o_fail_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("push_accepted", 64'(want.push_accepted),
                                64'(i_out_data.push_accepted));
                    check_field("frame_valid", 64'(want.frame_valid),
                                64'(i_out_data.frame_valid));
                    check_field("out_pts", want.out_pts, i_out_data.out_pts);
                    check_field("out_tag", 64'(want.out_tag), 64'(i_out_data.out_tag));
                    check_field("occupancy", 64'(want.occupancy), 64'(i_out_data.occupancy));
                    check_field("buffering", 64'(want.buffering), 64'(i_out_data.buffering));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = predict_result(i_in_data);
                awaited_results.push_back(want);
                o_items++;
                if (want.frame_valid)
                    o_frames++;
                if (i_in_data.func == FN_PUSH && !want.push_accepted)
                    o_refused++;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TARGET_LATENCY: target_ms = i_cfg_data[LAT_W-1:0];
                    CFG_MAX_CAPACITY:   capacity  = i_cfg_data[OCC_W-1:0];
                endcase
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression bench of the pts ordered jitter buffer: directed frames at the
// timestamp extremes and through every prebuffering exit, then random push,
// pop, tick and clear sequences over several latency and capacity settings
// with random gaps, random output stalls and a long output hold-off
// ----------------------------------------------------------------------------
module tb;
    import pojb_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic signed [PTS_W-1:0] PTS_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [PTS_W-1:0] PTS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_beat              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_beat             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_cnt;
    int pending;
    int items_done;
    int frames_out;
    int pushes_refused;
    int settings_run;
    int gap_pct;
    int stall_pct;
    int hold_req;
    int quiet_cycles;

    pts_ordered_jitter_buffer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pojb_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_items     (items_done),
        .o_frames    (frames_out),
        .o_refused   (pushes_refused)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [PTS_W-1:0] rand_pts();
        int sel;
        int near;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return {$urandom, $urandom};
        if (sel < 8) begin
            // narrow range so equal timestamps show up often
            near = int'($urandom_range(0, 16)) - 8;
            return PTS_W'(near);
        end
        if (sel == 8) begin
            case ($urandom_range(0, 3))
                0:       return PTS_MIN;
                1:       return PTS_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return PTS_W'(longint'($urandom_range(0, 5000)) * 40);
    endfunction

    // output side: runs of stall or go, plus one long hold on request
    initial begin : out_side
        int   run_left;
        logic run_stall;
        run_left  = 0;
        run_stall = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != 0) begin
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    run_stall = ($urandom_range(0, 99) < stall_pct);
                    run_left  = run_stall ? gap_len() : $urandom_range(1, 12);
                end
                out_stall <= run_stall;
                run_left--;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending);
                $display("pts_ordered_jitter_buffer regression: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input t_func f, input logic signed [PTS_W-1:0] pts,
                             input logic [TAG_W-1:0] tag);
        t_in_beat beat;
        int       idle;
        beat.func      = f;
        beat.frame_pts = pts;
        beat.frame_tag = tag;
        idle = ($urandom_range(0, 99) < gap_pct) ? gap_len() : 0;
        if (idle > 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [LAT_W-1:0] lat_ms, input logic [OCC_W-1:0] cap);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TARGET_LATENCY;
        cfg_data <= lat_ms;
        @(posedge clk);
        cfg_idx  <= CFG_MAX_CAPACITY;
        cfg_data <= CFG_DATA_W'(cap);
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_run++;
    endtask

    // mix of fill, drain and balanced stretches with random content
    task automatic run_random(input int count);
        int   i;
        int   r;
        int   push_w;
        int   pop_w;
        int   clear_w;
        t_func f;
        push_w  = 40;
        pop_w   = 35;
        clear_w = 2;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin push_w = 60; pop_w = 18; clear_w = 1; end
                    1: begin push_w = 20; pop_w = 55; clear_w = 2; end
                    default: begin push_w = 38; pop_w = 35; clear_w = 3; end
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < clear_w)
                f = FN_CLEAR;
            else if (r < clear_w + push_w)
                f = FN_PUSH;
            else if (r < clear_w + push_w + pop_w)
                f = FN_POP;
            else
                f = FN_TICK;
            send_item(f, rand_pts(), TAG_W'($urandom_range(0, 65535)));
        end
    endtask

    initial begin : stimulus
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_TARGET_LATENCY;
        cfg_data <= '0;
        hold_req     = 0;
        settings_run = 0;
        gap_pct      = 20;
        stall_pct    = 20;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: an empty pop, extremes of pts and tag, prebuffering holds
        send_item(FN_POP, '0, '0);
        send_item(FN_TICK, PTS_MAX, 16'hFFFF);
        send_item(FN_CLEAR, '0, '0);
        send_item(FN_PUSH, PTS_MAX, 16'hFFFF);
        send_item(FN_PUSH, PTS_MIN, 16'h0000);
        send_item(FN_PUSH, '0, 16'h1111);
        send_item(FN_PUSH, '0, 16'h2222);
        send_item(FN_PUSH, '1, 16'h3333);
        send_item(FN_POP, '0, '0);
        send_item(FN_TICK, '0, '0);
        send_item(FN_POP, '0, '0);
        send_item(FN_CLEAR, '0, '0);

        // short latency: exit by elapsed time, equal pts in arrival order
        set_regs(2, 64);
        send_item(FN_PUSH, 64'sd5, 16'hAAAA);
        send_item(FN_PUSH, 64'sd5, 16'hBBBB);
        send_item(FN_PUSH, 64'sd3, 16'hCCCC);
        send_item(FN_POP, '0, '0);
        send_item(FN_TICK, '0, '0);
        send_item(FN_TICK, '0, '0);
        send_item(FN_POP, '0, '0);
        send_item(FN_POP, '0, '0);
        send_item(FN_POP, '0, '0);
        send_item(FN_POP, '0, '0);

        // endless latency: exit only when full, capacity cut below occupancy
        set_regs('1, 3);
        send_item(FN_PUSH, 64'sd9, 16'h5A5A);
        send_item(FN_PUSH, -64'sd9, 16'hA5A5);
        send_item(FN_POP, '0, '0);
        set_regs('1, 1);
        send_item(FN_PUSH, 64'sd1, 16'h0F0F);
        send_item(FN_POP, '0, '0);
        set_regs(0, 0);
        send_item(FN_POP, '0, '0);
        send_item(FN_PUSH, 64'sd2, 16'hF0F0);
        send_item(FN_POP, '0, '0);

        set_regs(3, 64);
        gap_pct   = 30;
        stall_pct = 30;
        run_random(200);
        // output held off while input keeps coming
        hold_req = 1;
        run_random(150);

        set_regs(0, 64);
        gap_pct   = 0;
        stall_pct = 0;
        run_random(120);
        drain_results();
        gap_pct   = 40;
        stall_pct = 40;
        run_random(130);

        set_regs('1, 8);
        gap_pct   = 20;
        stall_pct = 50;
        run_random(250);

        set_regs(10, 127);
        gap_pct   = 35;
        stall_pct = 25;
        run_random(300);

        set_regs(1, 1);
        gap_pct   = 10;
        stall_pct = 10;
        run_random(150);

        set_regs(7, 0);
        run_random(80);

        set_regs(50, 64);
        gap_pct   = 25;
        stall_pct = 35;
        run_random(300);

        drain_results();
        $display("ran %0d items over %0d register settings", items_done, settings_run);
        $display("%0d frames delivered in pts order, %0d pushes refused at capacity",
                 frames_out, pushes_refused);
        if (fail_cnt == 0) begin
            $display("pts_ordered_jitter_buffer regression: pass");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("pts_ordered_jitter_buffer regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pojb_pkg.sv
rtl/pojb_ram.sv
rtl/pts_ordered_jitter_buffer.sv
sim/pojb_checker.sv
sim/tb.sv
